[hw/rtl/dps_pkg.sv]
// Package for the DER PACE info scanner: parse phases, scanner state record,
// DER tag and length codes, and the fixed PACE object identifier prefix.
// No dependencies.
package dps_pkg;

    typedef enum logic [3:0] {
        PH_TAG,
        PH_SET_LEN,
        PH_OID_LEN,
        PH_OTHER_LEN,
        PH_SKIP,
        PH_OID_BODY,
        PH_VER_TAG,
        PH_VER_LEN,
        PH_VER_VAL,
        PH_PAR_TAG,
        PH_PAR_LEN,
        PH_PAR_VAL,
        PH_DONE
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  skip_remaining;
        logic [7:0]  element_length;
        logic        prefix_match;
        logic [15:0] captured_tail;
        logic [7:0]  captured_version;
        logic [7:0]  captured_parameter;
        logic        pace_seen;
        logic        error_seen;
        logic [8:0]  error_position;
    } scan_state_t;

    localparam logic [7:0] TAG_SET      = 8'h31;
    localparam logic [7:0] TAG_SEQUENCE = 8'h30;
    localparam logic [7:0] TAG_OID      = 8'h06;
    localparam logic [7:0] TAG_INTEGER  = 8'h02;
    localparam logic [7:0] LEN_PACE_OID = 8'h0A;
    localparam logic [7:0] LEN_ONE      = 8'h01;
    localparam logic [7:0] LEN_LONG     = 8'h80;
    localparam logic [7:0] LEN_MASK     = 8'h7F;
    localparam logic [3:0] OID_PREFIX_LEN = 4'd8;
    localparam logic [3:0] OID_TAIL_HI    = 4'd8;

    localparam scan_state_t STATE_RESET = '{
        phase:              PH_TAG,
        skip_remaining:     8'd0,
        element_length:     8'd0,
        prefix_match:       1'b1,
        captured_tail:      16'd0,
        captured_version:   8'd0,
        captured_parameter: 8'd0,
        pace_seen:          1'b0,
        error_seen:         1'b0,
        error_position:     9'd0
    };

    function automatic logic [7:0] pace_prefix(input logic [2:0] idx);
        logic [7:0] val;
        case (idx)
            3'd0:    val = 8'h04;
            3'd1:    val = 8'h00;
            3'd2:    val = 8'h7F;
            3'd3:    val = 8'h00;
            3'd4:    val = 8'h07;
            3'd5:    val = 8'h02;
            3'd6:    val = 8'h02;
            3'd7:    val = 8'h04;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

    function automatic phase_t start_phase(input logic [7:0] b);
        phase_t ph;
        if (b == TAG_SET || b == TAG_SEQUENCE)
        begin
            ph = PH_SET_LEN;
        end
        else if (b == TAG_OID)
        begin
            ph = PH_OID_LEN;
        end
        else
        begin
            ph = PH_OTHER_LEN;
        end
        return ph;
    endfunction

endpackage

[hw/rtl/dps_step.sv]
// Next-state logic of the DER PACE info scanner for one message byte,
// including the zero-fill completion of an element cut off at the message end.
// Depends on dps_pkg.
module dps_step
(
    input  dps_pkg::scan_state_t cur,
    input  logic [7:0]           data_byte,
    input  logic [8:0]           pos,
    input  logic                 at_end,
    output dps_pkg::scan_state_t nxt
);

    dps_pkg::scan_state_t c;
    dps_pkg::scan_state_t f;
    logic                 consume_en;
    logic [3:0]           oid_idx;
    logic [7:0]           skip_dec;

    always_comb
    begin
        c          = cur;
        consume_en = (cur.phase != dps_pkg::PH_DONE) &&
                     !(at_end && (cur.phase == dps_pkg::PH_TAG ||
                                  cur.phase == dps_pkg::PH_PAR_TAG));
        oid_idx    = 4'd10 - cur.skip_remaining[3:0];
        skip_dec   = (cur.skip_remaining != 8'd0) ? cur.skip_remaining - 8'd1 : 8'd0;

        if (consume_en)
        begin
            case (cur.phase)
                dps_pkg::PH_TAG:
                begin
                    c.phase = dps_pkg::start_phase(data_byte);
                end
                dps_pkg::PH_SET_LEN:
                begin
                    if ((data_byte & dps_pkg::LEN_LONG) != 8'd0 &&
                        (data_byte & dps_pkg::LEN_MASK) != 8'd0)
                    begin
                        c.skip_remaining = data_byte & dps_pkg::LEN_MASK;
                        c.phase          = dps_pkg::PH_SKIP;
                    end
                    else
                    begin
                        c.phase = dps_pkg::PH_TAG;
                    end
                end
                dps_pkg::PH_OID_LEN:
                begin
                    if (data_byte == dps_pkg::LEN_PACE_OID)
                    begin
                        c.skip_remaining = dps_pkg::LEN_PACE_OID;
                        c.prefix_match   = 1'b1;
                        c.phase          = dps_pkg::PH_OID_BODY;
                    end
                    else if (data_byte != 8'd0)
                    begin
                        c.skip_remaining = data_byte;
                        c.phase          = dps_pkg::PH_SKIP;
                    end
                    else
                    begin
                        c.phase = dps_pkg::PH_TAG;
                    end
                end
                dps_pkg::PH_OTHER_LEN, dps_pkg::PH_PAR_LEN:
                begin
                    if (cur.phase == dps_pkg::PH_PAR_LEN && data_byte == dps_pkg::LEN_ONE)
                    begin
                        c.phase = dps_pkg::PH_PAR_VAL;
                    end
                    else if (data_byte == 8'd0)
                    begin
                        c.error_seen     = 1'b1;
                        c.error_position = pos - 9'd1;
                        c.phase          = dps_pkg::PH_DONE;
                    end
                    else
                    begin
                        c.skip_remaining = data_byte;
                        c.phase          = dps_pkg::PH_SKIP;
                    end
                end
                dps_pkg::PH_SKIP:
                begin
                    c.skip_remaining = skip_dec;
                    if (skip_dec == 8'd0)
                    begin
                        c.phase = dps_pkg::PH_TAG;
                    end
                end
                dps_pkg::PH_OID_BODY:
                begin
                    if (oid_idx < dps_pkg::OID_PREFIX_LEN &&
                        data_byte != dps_pkg::pace_prefix(oid_idx[2:0]))
                    begin
                        c.prefix_match = 1'b0;
                    end
                    if (oid_idx == dps_pkg::OID_TAIL_HI)
                    begin
                        c.element_length = data_byte;
                    end
                    c.skip_remaining = skip_dec;
                    if (skip_dec == 8'd0)
                    begin
                        if (c.prefix_match)
                        begin
                            c.captured_tail      = {c.element_length, data_byte};
                            c.captured_version   = 8'd0;
                            c.captured_parameter = 8'd0;
                            c.pace_seen          = 1'b0;
                            c.phase              = dps_pkg::PH_VER_TAG;
                        end
                        else
                        begin
                            c.phase = dps_pkg::PH_TAG;
                        end
                    end
                end
                dps_pkg::PH_VER_TAG:
                begin
                    if (data_byte == dps_pkg::TAG_INTEGER)
                    begin
                        c.phase = dps_pkg::PH_VER_LEN;
                    end
                    else
                    begin
                        c.error_seen     = 1'b1;
                        c.error_position = pos;
                        c.phase          = dps_pkg::PH_DONE;
                    end
                end
                dps_pkg::PH_VER_LEN:
                begin
                    if (data_byte == dps_pkg::LEN_ONE)
                    begin
                        c.phase = dps_pkg::PH_VER_VAL;
                    end
                    else
                    begin
                        c.error_seen     = 1'b1;
                        c.error_position = pos - 9'd1;
                        c.phase          = dps_pkg::PH_DONE;
                    end
                end
                dps_pkg::PH_VER_VAL:
                begin
                    c.captured_version = data_byte;
                    c.pace_seen        = 1'b1;
                    c.phase            = dps_pkg::PH_PAR_TAG;
                end
                dps_pkg::PH_PAR_TAG:
                begin
                    if (data_byte == dps_pkg::TAG_INTEGER)
                    begin
                        c.phase = dps_pkg::PH_PAR_LEN;
                    end
                    else
                    begin
                        c.phase = dps_pkg::start_phase(data_byte);
                    end
                end
                dps_pkg::PH_PAR_VAL:
                begin
                    c.captured_parameter = data_byte;
                    c.phase              = dps_pkg::PH_TAG;
                end
                default:
                begin
                    c.phase = dps_pkg::PH_DONE;
                end
            endcase
        end

        // At the message end, an open element is completed as if zero bytes followed.
        f = c;
        if (at_end)
        begin
            case (c.phase)
                dps_pkg::PH_OTHER_LEN, dps_pkg::PH_PAR_LEN, dps_pkg::PH_VER_LEN:
                begin
                    f.error_seen     = 1'b1;
                    f.error_position = pos;
                end
                dps_pkg::PH_VER_TAG:
                begin
                    f.error_seen     = 1'b1;
                    f.error_position = pos + 9'd1;
                end
                dps_pkg::PH_VER_VAL:
                begin
                    f.captured_version = 8'd0;
                    f.pace_seen        = 1'b1;
                end
                dps_pkg::PH_PAR_VAL:
                begin
                    f.captured_parameter = 8'd0;
                end
                dps_pkg::PH_OID_BODY:
                begin
                    if (c.prefix_match && c.skip_remaining <= 8'd2)
                    begin
                        f.captured_tail      = {(c.skip_remaining == 8'd1) ?
                                                c.element_length : 8'd0, 8'd0};
                        f.captured_version   = 8'd0;
                        f.captured_parameter = 8'd0;
                        f.pace_seen          = 1'b0;
                        f.error_seen         = 1'b1;
                        f.error_position     = pos + {1'b0, c.skip_remaining} + 9'd1;
                    end
                end
                default:
                begin
                    f = c;
                end
            endcase
            f.phase = dps_pkg::PH_DONE;
        end
        nxt = f;
    end

endmodule

[hw/rtl/der_pace_info_scanner.sv]
// Top level of the DER PACE info scanner: stream ports, scanner state and
// byte position registers, and the result register. Depends on dps_pkg and dps_step.
//
// The scanner takes one message byte per clock cycle and updates its parse state in
// the same cycle; the one result transaction appears in the cycle after the byte
// marked last and sits in the output register until the output side takes it.
// Input stalls only while a finished result waits and the output side is not ready.
// Only the first min(MAX_LEN, 511) bytes of a message are parsed; the result still
// waits for the last byte.
module der_pace_info_scanner
#(
    parameter int MAX_LEN = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // status, error_offset, pace_found, version,
                                        // domain_param, oid_tail, zero fill
);

    localparam int         PARSE_LIMIT = (MAX_LEN < 511) ? MAX_LEN : 511;
    localparam logic [8:0] LIMIT_POS   = 9'(PARSE_LIMIT);
    localparam logic [8:0] LAST_POS    = 9'(PARSE_LIMIT - 1);

    dps_pkg::scan_state_t state_reg;
    dps_pkg::scan_state_t state_next;
    dps_pkg::scan_state_t step_out;
    dps_pkg::scan_state_t state_after;
    logic [8:0]           pos_reg;
    logic [8:0]           pos_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [47:0]          out_data_reg;
    logic [47:0]          out_data_next;
    logic                 s_accept;
    logic                 in_range;
    logic                 at_end;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign in_range      = pos_reg < LIMIT_POS;
    assign at_end        = s_axis_tlast || (pos_reg == LAST_POS);

    dps_step u_step
    (
        .cur       (state_reg),
        .data_byte (s_axis_tdata),
        .pos       (pos_reg),
        .at_end    (at_end),
        .nxt       (step_out)
    );

    always_comb
    begin
        state_after    = in_range ? step_out : state_reg;
        state_next     = state_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        if (s_accept)
        begin
            if (s_axis_tlast)
            begin
                state_next     = dps_pkg::STATE_RESET;
                pos_next       = 9'd0;
                out_valid_next = 1'b1;
                out_data_next  = {5'd0,
                                  state_after.captured_tail,
                                  state_after.captured_parameter,
                                  state_after.captured_version,
                                  state_after.pace_seen,
                                  state_after.error_seen ? state_after.error_position : 9'd0,
                                  state_after.error_seen};
            end
            else
            begin
                state_next = state_after;
                pos_next   = in_range ? pos_reg + 9'd1 : pos_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dps_pkg::STATE_RESET;
            pos_reg       <= 9'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s_axis_tlast) |=> m_axis_tvalid)
        else $error("last byte accepted without a result");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && !s_axis_tlast && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("result produced without a last byte");

    a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LIMIT_POS)
        else $error("byte position beyond parse limit");

    a_error_stops: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.error_seen |-> (state_reg.phase == dps_pkg::PH_DONE))
        else $error("parser still active after an error");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s_axis_tlast) |=> (pos_reg == 9'd0 && !state_reg.error_seen))
        else $error("scanner state not cleared after a message");

endmodule
